// ===== rtl/aphq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aphq_pkg;

  localparam int COORD_WIDTH_DEF    = 20;
  localparam int PARAM_FRACTION_DEF = 16;
  localparam int ADDR_WIDTH         = 5;
  localparam int DATA_WIDTH         = 32;

  typedef enum logic [2:0] {
    REG_LO_X,
    REG_LO_Y,
    REG_LO_Z,
    REG_HI_X,
    REG_HI_Y,
    REG_HI_Z,
    REG_NE_HEIGHT,
    REG_SW_HEIGHT
  } reg_idx_t;

  // how a weight is formed: clamped low, clamped high, or divided out
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_DIV
  } weight_sel_t;

endpackage

`default_nettype wire

// ===== rtl/aphq_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aphq_cfg #(
  parameter int COORD_WIDTH = aphq_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [aphq_pkg::ADDR_WIDTH-1:0]     paddr,
  input  wire logic [aphq_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic      [aphq_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                     pready,
  output logic signed [COORD_WIDTH-1:0]            lo_x,
  output logic signed [COORD_WIDTH-1:0]            lo_y,
  output logic signed [COORD_WIDTH-1:0]            lo_z,
  output logic signed [COORD_WIDTH-1:0]            hi_x,
  output logic signed [COORD_WIDTH-1:0]            hi_y,
  output logic signed [COORD_WIDTH-1:0]            hi_z,
  output logic signed [COORD_WIDTH-1:0]            ne_height,
  output logic signed [COORD_WIDTH-1:0]            sw_height
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = aphq_pkg::DATA_WIDTH;

  aphq_pkg::reg_idx_t idx;
  logic               wr;
  logic signed [W-1:0] wval;

  assign idx    = aphq_pkg::reg_idx_t'(paddr[aphq_pkg::ADDR_WIDTH-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign wval   = $signed(pwdata[W-1:0]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_x      <= '0;
      lo_y      <= '0;
      lo_z      <= '0;
      hi_x      <= '0;
      hi_y      <= '0;
      hi_z      <= '0;
      ne_height <= '0;
      sw_height <= '0;
    end else if (wr) begin
      case (idx)
        aphq_pkg::REG_LO_X:      lo_x      <= wval;
        aphq_pkg::REG_LO_Y:      lo_y      <= wval;
        aphq_pkg::REG_LO_Z:      lo_z      <= wval;
        aphq_pkg::REG_HI_X:      hi_x      <= wval;
        aphq_pkg::REG_HI_Y:      hi_y      <= wval;
        aphq_pkg::REG_HI_Z:      hi_z      <= wval;
        aphq_pkg::REG_NE_HEIGHT: ne_height <= wval;
        aphq_pkg::REG_SW_HEIGHT: sw_height <= wval;
        default: ;
      endcase
    end
  end

  // read back sign-extended; low address bits select nothing
  always_comb begin
    case (idx)
      aphq_pkg::REG_LO_X:      prdata = DW'(lo_x);
      aphq_pkg::REG_LO_Y:      prdata = DW'(lo_y);
      aphq_pkg::REG_LO_Z:      prdata = DW'(lo_z);
      aphq_pkg::REG_HI_X:      prdata = DW'(hi_x);
      aphq_pkg::REG_HI_Y:      prdata = DW'(hi_y);
      aphq_pkg::REG_HI_Z:      prdata = DW'(hi_z);
      aphq_pkg::REG_NE_HEIGHT: prdata = DW'(ne_height);
      aphq_pkg::REG_SW_HEIGHT: prdata = DW'(sw_height);
      default:                 prdata = (paddr[1:0] == 2'b00) ? '0 : '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/aphq_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The numerator is known to be
// below the divisor whenever the select asks for a division.
module aphq_div #(
  parameter int COORD_WIDTH    = aphq_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRACTION = aphq_pkg::PARAM_FRACTION_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire aphq_pkg::weight_sel_t     sel_in,
  input  wire logic [COORD_WIDTH-1:0]    num,
  input  wire logic [COORD_WIDTH-1:0]    den,
  output logic      [PARAM_FRACTION:0]   wt
);

  localparam int W = COORD_WIDTH;
  localparam int F = PARAM_FRACTION;

  logic [W-1:0]          rem   [F];
  logic [F-1:0]          quo   [F];
  logic [W-1:0]          den_r [F];
  aphq_pkg::weight_sel_t sel_r [F];

  for (genvar k = 0; k < F; k++) begin : g_step
    logic [W-1:0]          rp;
    logic [W-1:0]          dp;
    logic [F-1:0]          qp;
    aphq_pkg::weight_sel_t sp;
    logic [W:0]            sh;
    logic [W:0]            diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rp = num;
      assign dp = den;
      assign qp = '0;
      assign sp = sel_in;
    end else begin : g_next
      assign rp = rem[k-1];
      assign dp = den_r[k-1];
      assign qp = quo[k-1];
      assign sp = sel_r[k-1];
    end

    assign sh   = {rp, 1'b0};
    assign diff = sh - {1'b0, dp};
    assign ge   = (sh >= {1'b0, dp});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? diff[W-1:0] : sh[W-1:0];
        quo[k]   <= {qp[F-2:0], ge};
        den_r[k] <= dp;
        sel_r[k] <= sp;
      end
    end
  end

  always_comb begin
    case (sel_r[F-1])
      aphq_pkg::SEL_ZERO: wt = '0;
      aphq_pkg::SEL_ONE:  wt = {1'b1, {F{1'b0}}};
      default:            wt = {1'b0, quo[F-1]};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/aphq_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bilinear height from weights u, v; five register stages.
module aphq_interp #(
  parameter int COORD_WIDTH    = aphq_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRACTION = aphq_pkg::PARAM_FRACTION_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic        [PARAM_FRACTION:0] u,
  input  wire logic        [PARAM_FRACTION:0] v,
  input  wire logic signed [COORD_WIDTH-1:0]  lo_z,
  input  wire logic signed [COORD_WIDTH-1:0]  ne_height,
  input  wire logic signed [COORD_WIDTH-1:0]  sw_height,
  input  wire logic signed [COORD_WIDTH-1:0]  hi_z,
  input  wire logic                          flat,
  output logic signed      [COORD_WIDTH-1:0]  height
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = PARAM_FRACTION;
  localparam int PW = W + F + 3;
  localparam logic signed [PW-1:0] BIAS = PW'((64'd1 << F) - 64'd1);

  // divide by 2^F, truncating toward zero
  function automatic logic signed [W:0] trunc_frac(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + ((p < 0) ? BIAS : '0);
    t = t >>> F;
    return t[W:0];
  endfunction

  logic signed [W:0]    dn;
  logic signed [W:0]    ds;
  logic signed [PW-1:0] pn1, ps1, pv4;
  logic        [F:0]    v1, v2, v3;
  logic signed [W-1:0]  north2, south2, north3, north4;
  logic signed [W:0]    diff3;
  logic signed [W:0]    sum_n, sum_s, sum_h;

  assign dn = (W+1)'(ne_height) - (W+1)'(lo_z);
  assign ds = (W+1)'(hi_z) - (W+1)'(sw_height);

  assign sum_n = (W+1)'(lo_z) + trunc_frac(pn1);
  assign sum_s = (W+1)'(sw_height) + trunc_frac(ps1);
  assign sum_h = (W+1)'(north4) + trunc_frac(pv4);

  always_ff @(posedge clk) begin
    if (en) begin
      pn1    <= $signed({1'b0, u}) * dn;
      ps1    <= $signed({1'b0, u}) * ds;
      v1     <= v;
      north2 <= sum_n[W-1:0];
      south2 <= sum_s[W-1:0];
      v2     <= v1;
      diff3  <= (W+1)'(south2) - (W+1)'(north2);
      north3 <= north2;
      v3     <= v2;
      pv4    <= $signed({1'b0, v3}) * diff3;
      north4 <= north3;
      height <= flat ? ne_height : sum_h[W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aphq_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sum of three squares: square stage, then sum stage.
module aphq_dist #(
  parameter int COORD_WIDTH = aphq_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [COORD_WIDTH:0] dx,
  input  wire logic signed [COORD_WIDTH:0] dy,
  input  wire logic signed [COORD_WIDTH:0] dz,
  output logic [2*COORD_WIDTH+3:0]         dsq
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 4;

  logic signed [2*W+1:0] sqx, sqy, sqz;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
      sqz <= dz * dz;
      dsq <= DW'(sqx) + DW'(sqy) + DW'(sqz);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/area_point_height_query_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Point query against one axis-aligned floor area. Program the extent and the
// four corner heights over APB while no item is in flight; then stream query
// points in and take one result per point: the inside flag, the bilinear floor
// height under the point, the closest point on the area and the squared
// distance to it. The block takes one item every clock while the output is not
// stalled; the u and v weights come from two restoring dividers that form one
// quotient bit per stage. A stall on the output freezes the whole pipeline
// without losing an item.
module area_point_height_query_unit #(
  parameter int COORD_WIDTH    = aphq_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRACTION = aphq_pkg::PARAM_FRACTION_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [aphq_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [aphq_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [aphq_pkg::DATA_WIDTH-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // pos_x, pos_y, pos_z
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // surface_z, near_x, near_y, near_z, dist_sq
  output logic [((6*COORD_WIDTH+11)/8)*8-1:0]  m_tdata,
  // inside_res
  output logic [0:0]                           m_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = PARAM_FRACTION;
  localparam int D      = F + 5;
  localparam int DW     = 2 * W + 4;
  localparam int OUT_TW = ((6 * W + 11) / 8) * 8;

  logic signed [W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, ne_height, sw_height;
  logic en, flat;

  aphq_cfg #(.COORD_WIDTH(W)) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y),
    .hi_z(hi_z), .ne_height(ne_height), .sw_height(sw_height)
  );

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign flat     = (hi_x <= lo_x) || (hi_y <= lo_y);

  // input stage
  logic                v1;
  logic signed [W-1:0] px1, py1, pz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= $signed(s_tdata[W-1:0]);
      py1 <= $signed(s_tdata[2*W-1:W]);
      pz1 <= $signed(s_tdata[3*W-1:2*W]);
    end
  end

  // region and weight setup
  logic                  xlo, xhi, ylo, yhi;
  logic signed [W-1:0]   chz;
  aphq_pkg::weight_sel_t selx, sely;

  assign xlo = px1 < lo_x;
  assign xhi = px1 > hi_x;
  assign ylo = py1 < lo_y;
  assign yhi = py1 > hi_y;
  assign chz = xlo ? (ylo ? lo_z : sw_height) : (ylo ? ne_height : hi_z);

  always_comb begin
    if (px1 <= lo_x) begin
      selx = aphq_pkg::SEL_ZERO;
    end else if (px1 >= hi_x) begin
      selx = aphq_pkg::SEL_ONE;
    end else begin
      selx = aphq_pkg::SEL_DIV;
    end
    if (py1 <= lo_y) begin
      sely = aphq_pkg::SEL_ZERO;
    end else if (py1 >= hi_y) begin
      sely = aphq_pkg::SEL_ONE;
    end else begin
      sely = aphq_pkg::SEL_DIV;
    end
  end

  logic                  v2, in2, int2;
  logic signed [W-1:0]   nx2, ny2, pz2;
  logic signed [W:0]     dx2, dy2, dzc2;
  logic [W-1:0]          numx2, denx2, numy2, deny2;
  aphq_pkg::weight_sel_t selx2, sely2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in2   <= !xlo && !xhi && !ylo && !yhi;
      int2  <= !(xlo || xhi) && !(ylo || yhi);
      nx2   <= xlo ? lo_x : (xhi ? hi_x : px1);
      ny2   <= ylo ? lo_y : (yhi ? hi_y : py1);
      pz2   <= pz1;
      dx2   <= xlo ? (W+1)'(lo_x) - (W+1)'(px1) :
               (xhi ? (W+1)'(hi_x) - (W+1)'(px1) : '0);
      dy2   <= ylo ? (W+1)'(lo_y) - (W+1)'(py1) :
               (yhi ? (W+1)'(hi_y) - (W+1)'(py1) : '0);
      dzc2  <= ((xlo || xhi) && (ylo || yhi)) ? (W+1)'(chz) - (W+1)'(pz1) : '0;
      numx2 <= W'(px1 - lo_x);
      denx2 <= W'(hi_x - lo_x);
      numy2 <= W'(py1 - lo_y);
      deny2 <= W'(hi_y - lo_y);
      selx2 <= selx;
      sely2 <= sely;
    end
  end

  logic [F:0]          u_w, v_w;
  logic signed [W-1:0] height;

  aphq_div #(.COORD_WIDTH(W), .PARAM_FRACTION(F)) u_div_x (
    .clk(clk), .en(en), .sel_in(selx2), .num(numx2), .den(denx2), .wt(u_w)
  );

  aphq_div #(.COORD_WIDTH(W), .PARAM_FRACTION(F)) u_div_y (
    .clk(clk), .en(en), .sel_in(sely2), .num(numy2), .den(deny2), .wt(v_w)
  );

  aphq_interp #(.COORD_WIDTH(W), .PARAM_FRACTION(F)) u_interp (
    .clk(clk), .en(en), .u(u_w), .v(v_w), .lo_z(lo_z), .ne_height(ne_height),
    .sw_height(sw_height), .hi_z(hi_z), .flat(flat), .height(height)
  );

  // carry the side fields alongside the dividers and interpolator
  logic                ln_v   [D];
  logic                ln_in  [D];
  logic                ln_int [D];
  logic signed [W-1:0] ln_nx  [D];
  logic signed [W-1:0] ln_ny  [D];
  logic signed [W-1:0] ln_pz  [D];
  logic signed [W:0]   ln_dx  [D];
  logic signed [W:0]   ln_dy  [D];
  logic signed [W:0]   ln_dzc [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) begin
        ln_v[k] <= 1'b0;
      end
    end else if (en) begin
      ln_v[0] <= v2;
      for (int k = 1; k < D; k++) begin
        ln_v[k] <= ln_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_in[0]  <= in2;
      ln_int[0] <= int2;
      ln_nx[0]  <= nx2;
      ln_ny[0]  <= ny2;
      ln_pz[0]  <= pz2;
      ln_dx[0]  <= dx2;
      ln_dy[0]  <= dy2;
      ln_dzc[0] <= dzc2;
      for (int k = 1; k < D; k++) begin
        ln_in[k]  <= ln_in[k-1];
        ln_int[k] <= ln_int[k-1];
        ln_nx[k]  <= ln_nx[k-1];
        ln_ny[k]  <= ln_ny[k-1];
        ln_pz[k]  <= ln_pz[k-1];
        ln_dx[k]  <= ln_dx[k-1];
        ln_dy[k]  <= ln_dy[k-1];
        ln_dzc[k] <= ln_dzc[k-1];
      end
    end
  end

  // distance terms
  logic                e_v, e_in;
  logic signed [W-1:0] e_nx, e_ny, e_sz;
  logic signed [W:0]   e_dx, e_dy, e_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= ln_v[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_in <= ln_in[D-1];
      e_nx <= ln_nx[D-1];
      e_ny <= ln_ny[D-1];
      e_sz <= height;
      e_dx <= ln_dx[D-1];
      e_dy <= ln_dy[D-1];
      e_dz <= ln_int[D-1] ? (W+1)'(height) - (W+1)'(ln_pz[D-1]) : ln_dzc[D-1];
    end
  end

  logic [DW-1:0] dsq;

  aphq_dist #(.COORD_WIDTH(W)) u_dist (
    .clk(clk), .en(en), .dx(e_dx), .dy(e_dy), .dz(e_dz), .dsq(dsq)
  );

  logic                f_v, f_in, o_in;
  logic signed [W-1:0] f_nx, f_ny, f_sz, o_nx, o_ny, o_sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      f_v      <= e_v;
      m_tvalid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_in <= e_in;
      f_nx <= e_nx;
      f_ny <= e_ny;
      f_sz <= e_sz;
      o_in <= f_in;
      o_nx <= f_nx;
      o_ny <= f_ny;
      o_sz <= f_sz;
    end
  end

  // the closest point shares the clamped weights, so its height is surface_z
  assign m_tdata = OUT_TW'({dsq, o_sz, o_ny, o_nx, o_sz});
  assign m_tuser = o_in;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    ln_v[F-1] |-> (u_w <= {1'b1, {F{1'b0}}}) && (v_w <= {1'b1, {F{1'b0}}}))
    else $error("interpolation weight above one");

  a_inside_no_offset: assert property (@(posedge clk) disable iff (rst)
    e_v && e_in |-> (e_dx == '0) && (e_dy == '0))
    else $error("inside point with horizontal offset");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CW = 20;
  localparam int FR = 16;
  localparam int DW = 2 * CW + 4;
  localparam int SW = ((3 * CW + 7) / 8) * 8;
  localparam int MW = ((6 * CW + 11) / 8) * 8;
  localparam int LAT = FR + 10;
  localparam int AW = aphq_pkg::ADDR_WIDTH;
  localparam int PW = aphq_pkg::DATA_WIDTH;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic          in_area;
    logic [CW-1:0] surf_z;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [CW-1:0] nz;
    logic [DW-1:0] dsq;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [PW-1:0] pwdata = '0;
  logic [PW-1:0] prdata;
  logic pready;
  logic s_tvalid = 0, s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [MW-1:0] m_tdata;
  logic [0:0] m_tuser;

  area_point_height_query_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // area registers mirrored for the predictor
  longint area [8];
  answer_t answers_due [$];
  int send_idle = 0, recv_idle = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint wgt(longint off, longint span);
    if (off <= 0) return 0;
    if (off >= span) return longint'(1) << FR;
    return (off << FR) / span;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + (w * (b - a)) / (longint'(1) << FR);
  endfunction

  function automatic longint floor_height(longint x, longint y);
    longint u, v, n, s, spx, spy;
    spx = area[aphq_pkg::REG_HI_X] - area[aphq_pkg::REG_LO_X];
    spy = area[aphq_pkg::REG_HI_Y] - area[aphq_pkg::REG_LO_Y];
    if (spx <= 0 || spy <= 0)
      return area[aphq_pkg::REG_NE_HEIGHT];
    u = wgt(x - area[aphq_pkg::REG_LO_X], spx);
    v = wgt(y - area[aphq_pkg::REG_LO_Y], spy);
    n = blend(area[aphq_pkg::REG_LO_Z], area[aphq_pkg::REG_NE_HEIGHT], u);
    s = blend(area[aphq_pkg::REG_SW_HEIGHT], area[aphq_pkg::REG_HI_Z], u);
    return blend(n, s, v);
  endfunction

  function automatic longint sq(longint d);
    return d * d;
  endfunction

  function automatic answer_t query_area(longint px, longint py, longint pz);
    answer_t a;
    longint lx, ly, hx, hy, nx, ny, nz, sz;
    longint d;
    lx = area[aphq_pkg::REG_LO_X]; ly = area[aphq_pkg::REG_LO_Y];
    hx = area[aphq_pkg::REG_HI_X]; hy = area[aphq_pkg::REG_HI_Y];
    a.in_area = px >= lx && px <= hx && py >= ly && py <= hy;
    sz = floor_height(px, py);
    if (px < lx) begin
      nx = lx;
      if (py < ly) begin
        ny = ly;
        d = sq(lx - px) + sq(ly - py) + sq(area[aphq_pkg::REG_LO_Z] - pz);
      end else if (py > hy) begin
        ny = hy;
        d = sq(lx - px) + sq(hy - py) + sq(area[aphq_pkg::REG_SW_HEIGHT] - pz);
      end else begin
        ny = py; d = sq(lx - px);
      end
    end else if (px > hx) begin
      nx = hx;
      if (py < ly) begin
        ny = ly;
        d = sq(hx - px) + sq(ly - py) + sq(area[aphq_pkg::REG_NE_HEIGHT] - pz);
      end else if (py > hy) begin
        ny = hy;
        d = sq(hx - px) + sq(hy - py) + sq(area[aphq_pkg::REG_HI_Z] - pz);
      end else begin
        ny = py; d = sq(px - hx);
      end
    end else if (py < ly) begin
      nx = px; ny = ly; d = sq(ly - py);
    end else if (py > hy) begin
      nx = px; ny = hy; d = sq(py - hy);
    end else begin
      nx = px; ny = py; d = sq(sz - pz);
    end
    nz = floor_height(nx, ny);
    a.surf_z = sz[CW-1:0];
    a.nx = nx[CW-1:0];
    a.ny = ny[CW-1:0];
    a.nz = nz[CW-1:0];
    a.dsq = d[DW-1:0];
    return a;
  endfunction

  task automatic write_reg(aphq_pkg::reg_idx_t idx, longint val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= AW'(4 * int'(idx));
    pwdata <= PW'(val);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    area[idx] = sx(val[CW-1:0]);
  endtask

  // leaves tvalid high until an idle cycle or a drain drops it
  task automatic send_point(longint px, longint py, longint pz);
    logic [CW-1:0] x, y, z;
    x = px[CW-1:0]; y = py[CW-1:0]; z = pz[CW-1:0];
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= SW'({z, y, x});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    answers_due.push_back(query_area(sx(x), sx(y), sx(z)));
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_area(longint lx, longint ly, longint hx, longint hy,
                          longint z0, longint z1, longint z2, longint z3);
    write_reg(aphq_pkg::REG_LO_X, lx); write_reg(aphq_pkg::REG_LO_Y, ly);
    write_reg(aphq_pkg::REG_HI_X, hx); write_reg(aphq_pkg::REG_HI_Y, hy);
    write_reg(aphq_pkg::REG_LO_Z, z0); write_reg(aphq_pkg::REG_HI_Z, z1);
    write_reg(aphq_pkg::REG_NE_HEIGHT, z2); write_reg(aphq_pkg::REG_SW_HEIGHT, z3);
  endtask

  function automatic longint rnd_coord();
    return sx(CW'($urandom));
  endfunction

  // point near the extent so every region is hit
  function automatic longint near_range(longint a, longint b);
    longint lo, hi;
    lo = (a < b ? a : b) - 64; hi = (a < b ? b : a) + 64;
    case ($urandom_range(5))
      0: return a;
      1: return b;
      2: return rnd_coord();
      default: return lo + longint'($urandom_range(int'(hi - lo)));
    endcase
  endfunction

  task automatic test_directed;
    longint mx, mn;
    mx = (longint'(1) << (CW - 1)) - 1; mn = -(longint'(1) << (CW - 1));
    send_point(0, 0, 0);
    drain();
    set_area(-100, -50, 300, 200, 40, -80, 120, -30);
    send_point(-100, -50, 5); send_point(300, 200, -5); send_point(100, 75, 0);
    send_point(-200, -100, 7); send_point(400, -100, 9); send_point(-200, 300, 1);
    send_point(400, 300, 3); send_point(-200, 70, 0); send_point(400, 70, 0);
    send_point(50, -90, 0); send_point(50, 260, 0); send_point(mx, mx, mx);
    send_point(mn, mn, mn); send_point(mn, mx, 0); send_point(mx, mn, mx);
    drain();
    set_area(mn, mn, mx, mx, mx, mn, mx, mn);
    send_point(mx, mx, mn); send_point(mn, mn, mx); send_point(0, 0, 0);
    send_point(-1, 1, -1);
    drain();
    // flat in x, then inverted in y
    set_area(10, 10, 10, 90, 5, 6, 77, 8);
    send_point(10, 50, 0); send_point(11, 5, 3);
    drain();
    set_area(10, 90, 60, 10, 5, 6, -77, 8);
    send_point(30, 50, 0); send_point(30, 95, 2); send_point(30, 5, 2);
    drain();
  endtask

  task automatic test_random(int n);
    longint lx, ly, hx, hy, sp;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        drain();
        sp = (i % 300 == 0) ? 1 << 18 : 4000;
        lx = rnd_coord() / 4; ly = rnd_coord() / 4;
        hx = lx + longint'($urandom_range(int'(sp)));
        hy = ly + longint'($urandom_range(int'(sp)));
        if ($urandom_range(9) == 0) hx = lx - longint'($urandom_range(5));
        set_area(lx, ly, hx, hy, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      end
      send_point(near_range(area[aphq_pkg::REG_LO_X], area[aphq_pkg::REG_HI_X]),
                 near_range(area[aphq_pkg::REG_LO_Y], area[aphq_pkg::REG_HI_Y]),
                 rnd_coord());
    end
    drain();
  endtask

  always @(posedge clk) begin
    answer_t want, got;
    cycles <= cycles + 1;
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tdata[3*CW-1:2*CW],
             m_tdata[4*CW-1:3*CW], m_tdata[4*CW+DW-1:4*CW]};
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("item wrong: exp in=%b sz=%h n=%h,%h,%h d=%h got in=%b sz=%h n=%h,%h,%h d=%h",
                     want.in_area, want.surf_z, want.nx, want.ny, want.nz, want.dsq,
                     got.in_area, got.surf_z, got.nx, got.ny, got.nz, got.dsq);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("area_point_height_query_unit: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) area[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    test_directed();
    send_idle = 25; recv_idle = 83;
    test_random(280);
    send_idle = 83; recv_idle = 25;
    test_random(280);
    send_idle = 0; recv_idle = 0;
    test_random(290);
    if (errors == 0 && answers_due.size() == 0)
      $display("area_point_height_query_unit: match");
    else
      $display("area_point_height_query_unit: mismatch");
    $finish;
  end

endmodule

// ===== area_point_height_query_unit.f =====
rtl/aphq_pkg.sv
rtl/aphq_cfg.sv
rtl/aphq_div.sv
rtl/aphq_interp.sv
rtl/aphq_dist.sv
rtl/area_point_height_query_unit.sv
tb/sv/tb.sv
